### sv/range_min_segment_tree_defines.svh
// assertion macros shared by the range-minimum tree checker
`ifndef RANGE_MIN_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_DEFINES_SVH

// implication checked in the same cycle, off while reset is high
`define RMST_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmst: implication check failed");

// property of the cycle that follows a reset cycle
`define RMST_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("rmst: post-reset check failed");

`endif

### sv/rmst_pkg.sv
// shared types, codes and helpers of the range-minimum segment tree
`timescale 1ns / 1ps

package rmst_pkg;

   localparam int IDX_W          = 10;
   localparam int REND_W         = 11;
   localparam int VAL_W          = 64;
   localparam int LEAVES_DEFAULT = 1024;

   localparam logic signed [VAL_W-1:0] EMPTY_VALUE = 64'sd1000000000000000000;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam int STEP_W = 4;
   localparam int COND_W = 4;

   // branch conditions of the control store
   localparam logic [COND_W-1:0] COND_ALWAYS      = 4'd0;
   localparam logic [COND_W-1:0] COND_NO_REQ      = 4'd1;
   localparam logic [COND_W-1:0] COND_UPDATE      = 4'd2;
   localparam logic [COND_W-1:0] COND_SKIP        = 4'd3;
   localparam logic [COND_W-1:0] COND_RANGE_DONE  = 4'd4;
   localparam logic [COND_W-1:0] COND_RSP_FULL    = 4'd5;
   localparam logic [COND_W-1:0] COND_LEAF_ROOT   = 4'd6;
   localparam logic [COND_W-1:0] COND_PARENT_ROOT = 4'd7;
   localparam logic [COND_W-1:0] COND_CLEAR_LAST  = 4'd8;

   // read address select
   localparam logic [1:0] RD_LO       = 2'd0;
   localparam logic [1:0] RD_HI_M1    = 2'd1;
   localparam logic [1:0] RD_SIB      = 2'd2;
   localparam logic [1:0] RD_PAR_SIB  = 2'd3;

   // write select
   localparam logic [1:0] WR_NONE     = 2'd0;
   localparam logic [1:0] WR_LEAF     = 2'd1;
   localparam logic [1:0] WR_PARENT   = 2'd2;
   localparam logic [1:0] WR_CLEAR    = 2'd3;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] tgt_t;
      logic [STEP_W-1:0] tgt_f;
      logic              req_ready;
      logic [1:0]        rd_sel;
      logic [1:0]        wr_sel;
      logic              acc_l_en;
      logic              acc_r_en;
      logic              walk_en;
      logic              rsp_load;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic is_update;
      logic skip;
      logic range_done;
      logic rsp_full;
      logic leaf_root;
      logic parent_root;
      logic clear_last;
   } flags_type;

   function automatic logic signed [VAL_W-1:0] min64(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

endpackage

### sv/rmst_sequencer.sv
// control store, step counter and branch logic of the range-minimum tree
`timescale 1ns / 1ps

module rmst_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  rmst_pkg::flags_type flags,
   output rmst_pkg::ctrl_type  ctrl
);
   import rmst_pkg::*;

   localparam logic [STEP_W-1:0] ST_WAIT     = 4'd0;
   localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
   localparam logic [STEP_W-1:0] ST_Q_TEST   = 4'd2;
   localparam logic [STEP_W-1:0] ST_Q_STEP   = 4'd3;
   localparam logic [STEP_W-1:0] ST_Q_OUT    = 4'd4;
   localparam logic [STEP_W-1:0] ST_U_CHECK  = 4'd5;
   localparam logic [STEP_W-1:0] ST_U_LEAF   = 4'd6;
   localparam logic [STEP_W-1:0] ST_U_LEVEL  = 4'd7;
   localparam logic [STEP_W-1:0] ST_CLEAR    = 4'd8;

   function automatic ctrl_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '0;
      w.cond   = COND_ALWAYS;
      w.tgt_t  = ST_WAIT;
      w.tgt_f  = ST_WAIT;
      w.rd_sel = RD_LO;
      w.wr_sel = WR_NONE;
      case (step)
         ST_WAIT: begin
            w.cond      = COND_NO_REQ;
            w.tgt_t     = ST_WAIT;
            w.tgt_f     = ST_DISPATCH;
            w.req_ready = 1'b1;
         end
         ST_DISPATCH: begin
            w.cond  = COND_UPDATE;
            w.tgt_t = ST_U_CHECK;
            w.tgt_f = ST_Q_TEST;
         end
         // read the left border node, fold in the right node read last step
         ST_Q_TEST: begin
            w.cond     = COND_RANGE_DONE;
            w.tgt_t    = ST_Q_OUT;
            w.tgt_f    = ST_Q_STEP;
            w.rd_sel   = RD_LO;
            w.acc_r_en = 1'b1;
         end
         ST_Q_STEP: begin
            w.cond     = COND_ALWAYS;
            w.tgt_t    = ST_Q_TEST;
            w.tgt_f    = ST_Q_TEST;
            w.rd_sel   = RD_HI_M1;
            w.acc_l_en = 1'b1;
            w.walk_en  = 1'b1;
         end
         ST_Q_OUT: begin
            w.cond     = COND_RSP_FULL;
            w.tgt_t    = ST_Q_OUT;
            w.tgt_f    = ST_WAIT;
            w.rsp_load = 1'b1;
         end
         ST_U_CHECK: begin
            w.cond  = COND_SKIP;
            w.tgt_t = ST_WAIT;
            w.tgt_f = ST_U_LEAF;
         end
         ST_U_LEAF: begin
            w.cond   = COND_LEAF_ROOT;
            w.tgt_t  = ST_WAIT;
            w.tgt_f  = ST_U_LEVEL;
            w.rd_sel = RD_SIB;
            w.wr_sel = WR_LEAF;
         end
         // one ancestor per cycle: sibling read one step ahead
         ST_U_LEVEL: begin
            w.cond   = COND_PARENT_ROOT;
            w.tgt_t  = ST_WAIT;
            w.tgt_f  = ST_U_LEVEL;
            w.rd_sel = RD_PAR_SIB;
            w.wr_sel = WR_PARENT;
         end
         ST_CLEAR: begin
            w.cond   = COND_CLEAR_LAST;
            w.tgt_t  = ST_WAIT;
            w.tgt_f  = ST_CLEAR;
            w.wr_sel = WR_CLEAR;
         end
         default: begin
            w.cond  = COND_ALWAYS;
            w.tgt_t = ST_WAIT;
            w.tgt_f = ST_WAIT;
         end
      endcase
      return w;
   endfunction

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic              cond_hit;

   assign ctrl = rom_word(upc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:      cond_hit = 1'b1;
         COND_NO_REQ:      cond_hit = !flags.req_valid;
         COND_UPDATE:      cond_hit = flags.is_update;
         COND_SKIP:        cond_hit = flags.skip;
         COND_RANGE_DONE:  cond_hit = flags.range_done;
         COND_RSP_FULL:    cond_hit = flags.rsp_full;
         COND_LEAF_ROOT:   cond_hit = flags.leaf_root;
         COND_PARENT_ROOT: cond_hit = flags.parent_root;
         COND_CLEAR_LAST:  cond_hit = flags.clear_last;
         default:          cond_hit = 1'b1;
      endcase
      upc_in = cond_hit ? ctrl.tgt_t : ctrl.tgt_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

### sv/range_min_segment_tree.sv
// range-minimum segment tree: node store, datapath and output register
// update: one ancestor per cycle, from the leaf up to the root.
// query: k <= log2(2*LEAVES) levels walked; two node reads per level share the single
//   read port of the node memory, and the result waits while the output is stalled.
// reset: synchronous, then a clearing pass writes 1e18 to all 2*LEAVES nodes, one per
//   cycle, with req_ready low until it ends.
`timescale 1ns / 1ps

module range_min_segment_tree #(
   parameter int LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic        [rmst_pkg::IDX_W-1:0]   req_index,
   input  logic        [rmst_pkg::REND_W-1:0]  req_right_end,
   input  logic signed [rmst_pkg::VAL_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rmst_pkg::VAL_W-1:0]   rsp_min_value
);
   import rmst_pkg::*;

   localparam int MAW = $clog2(2 * LEAVES);
   localparam int NW  = $clog2(2 * LEAVES + 1);
   localparam int EW  = (NW > REND_W) ? NW : REND_W;

   ctrl_type  ctrl;
   flags_type flags;

   logic signed [VAL_W-1:0] mem [0:2*LEAVES-1];

   logic signed [VAL_W-1:0] rdata_ff;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] acc_l_ff, acc_l_in;
   logic signed [VAL_W-1:0] acc_r_ff, acc_r_in;
   logic signed [VAL_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [VAL_W-1:0] node_min;
   logic signed [VAL_W-1:0] wr_data;

   logic [NW-1:0]  lo_ff, lo_in;
   logic [NW-1:0]  hi_ff, hi_in;
   logic [NW-1:0]  par;
   logic [NW-1:0]  hi_m1;
   logic [MAW-1:0] clr_ff, clr_in;
   logic [MAW-1:0] rd_addr;
   logic [MAW-1:0] wr_addr;
   logic           wr_en;

   logic hodd_ff, hodd_in;
   logic op_ff, op_in;
   logic skip_ff, skip_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic rsp_full;
   logic rsp_load;

   logic [EW-1:0] idx_e, rend_e, leaves_e, hi_sat, lo_node_e, hi_node_e;

   rmst_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign req_ready     = ctrl.req_ready;
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_full      = rsp_valid_ff && !rsp_ready;
   assign rsp_load      = ctrl.rsp_load && !rsp_full;

   assign idx_e     = EW'(req_index);
   assign rend_e    = EW'(req_right_end);
   assign leaves_e  = EW'(LEAVES);
   assign hi_sat    = (rend_e > leaves_e) ? leaves_e : rend_e;
   assign lo_node_e = idx_e + leaves_e;
   assign hi_node_e = hi_sat + leaves_e;

   assign par      = lo_ff >> 1;
   assign hi_m1    = hi_ff - NW'(1);
   assign node_min = min64(val_ff, rdata_ff);

   assign flags.req_valid   = req_valid;
   assign flags.is_update   = (op_ff == OP_UPDATE);
   assign flags.skip        = skip_ff;
   assign flags.range_done  = !(lo_ff < hi_ff);
   assign flags.rsp_full    = rsp_full;
   assign flags.leaf_root   = (lo_ff == NW'(1));
   assign flags.parent_root = (par == NW'(1));
   assign flags.clear_last  = (clr_ff == MAW'(2 * LEAVES - 1));

   always_comb begin
      case (ctrl.rd_sel)
         RD_LO:      rd_addr = lo_ff[MAW-1:0];
         RD_HI_M1:   rd_addr = hi_m1[MAW-1:0];
         RD_SIB:     rd_addr = lo_ff[MAW-1:0] ^ MAW'(1);
         RD_PAR_SIB: rd_addr = par[MAW-1:0] ^ MAW'(1);
         default:    rd_addr = lo_ff[MAW-1:0];
      endcase
   end

   always_comb begin
      case (ctrl.wr_sel)
         WR_LEAF: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[MAW-1:0];
            wr_data = val_ff;
         end
         WR_PARENT: begin
            wr_en   = 1'b1;
            wr_addr = par[MAW-1:0];
            wr_data = node_min;
         end
         WR_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = EMPTY_VALUE;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = lo_ff[MAW-1:0];
            wr_data = val_ff;
         end
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      skip_in  = skip_ff;
      val_in   = val_ff;
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      hodd_in  = hodd_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;

      if (accept) begin
         op_in    = req_opcode;
         skip_in  = (idx_e >= leaves_e);
         val_in   = req_value;
         acc_l_in = EMPTY_VALUE;
         acc_r_in = EMPTY_VALUE;
         hodd_in  = 1'b0;
         // empty or reversed range: equal borders end the walk at once
         if (req_opcode == OP_QUERY && idx_e >= hi_sat) begin
            lo_in = '0;
            hi_in = '0;
         end else begin
            lo_in = lo_node_e[NW-1:0];
            hi_in = hi_node_e[NW-1:0];
         end
      end

      if (ctrl.acc_r_en && hodd_ff) begin
         acc_r_in = min64(rdata_ff, acc_r_ff);
      end
      if (ctrl.acc_l_en && lo_ff[0]) begin
         acc_l_in = min64(acc_l_ff, rdata_ff);
      end
      if (ctrl.walk_en) begin
         lo_in   = par + NW'(lo_ff[0]);
         hi_in   = hi_ff >> 1;
         hodd_in = hi_ff[0];
      end
      if (ctrl.wr_sel == WR_PARENT) begin
         val_in = node_min;
         lo_in  = par;
      end
   end

   assign rsp_valid_in = rsp_load || rsp_full;
   assign rsp_min_in   = rsp_load ? min64(acc_l_ff, acc_r_ff) : rsp_min_ff;
   assign clr_in       = (ctrl.wr_sel == WR_CLEAR) ? clr_ff + MAW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      skip_ff    <= skip_in;
      val_ff     <= val_in;
      acc_l_ff   <= acc_l_in;
      acc_r_ff   <= acc_r_in;
      hodd_ff    <= hodd_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rsp_min_ff <= rsp_min_in;
   end

endmodule

### sv/rmst_checker.sv
// port-level checks of the range-minimum tree and their bind to the top level
`timescale 1ns / 1ps
`include "range_min_segment_tree_defines.svh"

module rmst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [rmst_pkg::VAL_W-1:0] rsp_min_value
);
   import rmst_pkg::*;

   // a stalled result keeps its item
   `RMST_ASSERT_IMPLY(a_rsp_hold, $past(rsp_valid && !rsp_ready), rsp_valid && $stable(rsp_min_value))
   // a result never shows up in the cycle right after an item was taken
   `RMST_ASSERT_IMPLY(a_rsp_not_early, $rose(rsp_valid), !$past(req_valid && req_ready))
   // nothing is taken while the node store is being cleared
   `RMST_ASSERT_AFTER_RESET(a_clear_not_ready, !req_ready)
   `RMST_ASSERT_AFTER_RESET(a_reset_no_rsp, !rsp_valid)

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_min_value (rsp_min_value)
);
